### sv/mmre_pkg.sv
// Shared types, constants and helpers for the mark matrix row encoder.
// Used by every module of the block; depends on nothing else.
package mmre_pkg;

  localparam int CFG_W  = 13;
  localparam int MARK_W = 2;
  localparam int CODE_W = 15;
  localparam int LEN_W  = 4;
  localparam int BITS_W = 4;
  localparam int IDX_W  = 1;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_W-1:0] RESET_SIZE = CFG_W'(4096);

  localparam logic [IDX_W-1:0] REG_ROW_WIDTH    = 1'b0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [MARK_W-1:0] MARK_NONE   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_START  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_END    = 2'd2;
  localparam logic [MARK_W-1:0] MARK_SINGLE = 2'd3;

  localparam logic [2:0] PFX_START  = 3'b011;
  localparam logic [2:0] PFX_END    = 3'b101;
  localparam logic [2:0] PFX_SINGLE = 3'b100;
  localparam logic [1:0] PLEN_SHORT = 2'd2;
  localparam logic [1:0] PLEN_LONG  = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } size_t;

  // Smallest b >= 1 with 2^b >= n: one plus the top set bit of n - 1.
  function automatic logic [BITS_W-1:0] offset_bits(input logic [CFG_W-1:0] n);
    logic [CFG_W-1:0]  m;
    logic [BITS_W-1:0] b;
    m = n - CFG_W'(1);
    b = BITS_W'(1);
    if (n > CFG_W'(1)) begin
      for (int i = 0; i < CFG_W; i++) begin
        if (m[i]) begin
          b = BITS_W'(i + 1);
        end
      end
    end
    return b;
  endfunction

endpackage

### sv/mmre_cfg_regs.sv
// Configuration registers of the mark matrix row encoder and the clamped sizes.
// Depends on mmre_pkg.
module mmre_cfg_regs #(
  parameter int MAX_WIDTH  = mmre_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mmre_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [mmre_pkg::IDX_W-1:0] cfg_index,
  input  logic [mmre_pkg::CFG_W-1:0] cfg_data,
  output mmre_pkg::size_t            sizes
);
  import mmre_pkg::*;

  logic [CFG_W-1:0] row_width_r;
  logic [CFG_W-1:0] image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= RESET_SIZE;
      image_height_r <= RESET_SIZE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_WIDTH:    row_width_r    <= cfg_data;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A size of zero behaves as one; sizes beyond the build limit saturate.
  always_comb begin
    if (row_width_r == '0) begin
      sizes.width = CFG_W'(1);
    end else if (32'(row_width_r) > 32'(MAX_WIDTH)) begin
      sizes.width = CFG_W'(MAX_WIDTH);
    end else begin
      sizes.width = row_width_r;
    end
    if (image_height_r == '0) begin
      sizes.height = CFG_W'(1);
    end else if (32'(image_height_r) > 32'(MAX_HEIGHT)) begin
      sizes.height = CFG_W'(MAX_HEIGHT);
    end else begin
      sizes.height = image_height_r;
    end
  end

endmodule

### sv/mmre_code_gen.sv
// Codeword builder: prefix from the mark, offset field sized from the columns left.
// Depends on mmre_pkg.
module mmre_code_gen #(
  parameter int CNT_W = 12
) (
  input  logic [mmre_pkg::MARK_W-1:0] mark,
  input  logic [CNT_W-1:0]            col,
  input  logic [CNT_W-1:0]            prev_col,
  input  logic                        seen,
  input  logic                        last_col,
  input  logic [mmre_pkg::CFG_W-1:0]  width,
  output logic                        emit,
  output logic [mmre_pkg::CODE_W-1:0] code_bits,
  output logic [mmre_pkg::LEN_W-1:0]  code_length
);
  import mmre_pkg::*;

  logic [2:0]        prefix;
  logic [1:0]        plen;
  logic [31:0]       used;
  logic [CFG_W-1:0]  remaining;
  logic [BITS_W-1:0] nbits;
  logic [CNT_W-1:0]  offset;
  logic [31:0]       code_full;
  logic [BITS_W:0]   len_full;

  always_comb begin
    unique case (mark)
      MARK_START: begin
        prefix = PFX_START;
        plen   = PLEN_SHORT;
      end
      MARK_END: begin
        prefix = PFX_END;
        plen   = PLEN_LONG;
      end
      MARK_SINGLE: begin
        prefix = PFX_SINGLE;
        plen   = PLEN_LONG;
      end
      default: begin
        prefix = PFX_SINGLE;
        plen   = PLEN_LONG;
      end
    endcase
  end

  assign used      = 32'(prev_col) + 32'(seen);
  assign remaining = (32'(width) > used) ? CFG_W'(32'(width) - used) : '0;
  assign nbits     = offset_bits(remaining);
  assign offset    = seen ? (col - prev_col - CNT_W'(1)) : col;

  assign code_full = (32'(prefix) << nbits) | (32'(offset) & ((32'd1 << nbits) - 32'd1));
  assign len_full  = (BITS_W+1)'(plen) + (BITS_W+1)'(nbits);

  always_comb begin
    if (mark != MARK_NONE) begin
      emit        = 1'b1;
      code_bits   = code_full[CODE_W-1:0];
      code_length = len_full[LEN_W-1:0];
    end else begin
      // A blank pixel closing a row sends a single zero bit.
      emit        = last_col;
      code_bits   = '0;
      code_length = LEN_W'(1);
    end
  end

endmodule

### sv/mark_matrix_row_encoder.sv
// Mark matrix row encoder: each input beat passes the input register, then the result register.
// Throughput one mark per cycle; the input register, codeword logic and result
// register form a two-stage pipeline that stalls only on out_stall.
// Synchronous active-low reset clears the row/column state, the pipeline valids
// and sets both size registers to 4096.
module mark_matrix_row_encoder #(
  parameter int MAX_WIDTH  = mmre_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mmre_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mmre_pkg::IDX_W-1:0]  cfg_index,
  input  logic [mmre_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mmre_pkg::MARK_W-1:0] in_mark_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mmre_pkg::CODE_W-1:0] out_code_bits,
  output logic [mmre_pkg::LEN_W-1:0]  out_code_length,
  output logic                        out_end_of_image
);
  import mmre_pkg::*;

  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  size_t sizes;

  logic              s1_valid_r;
  logic [MARK_W-1:0] s1_mark_r;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  prev_r, prev_nxt;
  logic              seen_r, seen_nxt;
  logic              out_valid_r;
  logic [CODE_W-1:0] code_r;
  logic [LEN_W-1:0]  len_r;
  logic              eoi_r;

  logic              out_free;
  logic              adv;
  logic              last_col;
  logic              last_row;
  logic              emit;
  logic [CODE_W-1:0] code;
  logic [LEN_W-1:0]  len;

  mmre_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sizes    (sizes)
  );

  // Counters past the end after a size change count as the last position.
  assign last_col = (32'(col_r) + 32'd1) >= 32'(sizes.width);
  assign last_row = (32'(row_r) + 32'd1) >= 32'(sizes.height);

  mmre_code_gen #(
    .CNT_W(CNT_W)
  ) u_gen (
    .mark       (s1_mark_r),
    .col        (col_r),
    .prev_col   (prev_r),
    .seen       (seen_r),
    .last_col   (last_col),
    .width      (sizes.width),
    .emit       (emit),
    .code_bits  (code),
    .code_length(len)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    prev_nxt = prev_r;
    seen_nxt = seen_r;
    if (adv) begin
      if (s1_mark_r != MARK_NONE) begin
        prev_nxt = col_r;
        seen_nxt = 1'b1;
      end
      if (last_col) begin
        col_nxt  = '0;
        prev_nxt = '0;
        seen_nxt = 1'b0;
        row_nxt  = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      prev_r      <= '0;
      seen_r      <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= adv && emit;
      end
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      prev_r <= prev_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_mark_r <= in_mark_value;
    end
    if (adv) begin
      code_r <= code;
      len_r  <= len;
      eoi_r  <= last_col && last_row;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_bits    = code_r;
  assign out_code_length  = len_r;
  assign out_end_of_image = eoi_r;

`ifndef SYNTH
  // A nonzero mark that does not close the row leaves the row marked as seen.
  a_seen_after_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_mark_r != MARK_NONE && !last_col) |=> seen_r)
    else $error("mark seen flag not set after a nonzero mark");

  // The last pixel of an image returns both counters to the origin.
  a_image_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_col && last_row) |=> (col_r == '0 && row_r == '0))
    else $error("counters not cleared at end of image");

  // Without a mark in the row the previous mark column stays cleared.
  a_prev_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> (prev_r == '0))
    else $error("previous mark column set with no mark seen");

  // A delivered beat always carries at least one code bit.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (len_r != '0))
    else $error("result beat with empty codeword");
`endif

endmodule
